@@ hdl/vienc_pkg.sv @@
// Shared types and constants of the bijective base-128 varint encoder.
package vienc_pkg;

    localparam int MAX_BYTES = 10;
    localparam int VALUE_W   = 64;
    localparam int DIGIT_W   = 7;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = $clog2(MAX_BYTES);

    localparam logic [DIGIT_W-1:0] DIGIT_MASK = 7'h7F;
    localparam logic [BYTE_W-1:0]  CONT_BIT   = 8'h80;

    // Register indexes of the configuration port
    localparam logic REG_SIGNED_MODE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_READ,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [VALUE_W-1:0] next_value;
        logic               done;
    } digit_step_t;

endpackage

@@ hdl/varint_encoder_msb_first.sv @@
// Top level of the bijective base-128 varint encoder, most significant group first.
//
// Takes one 64-bit word on the value channel and returns its bijective base-128
// varint on the byte channel, one byte per transfer, most significant group first.
// Every byte but the final one has bit 7 set, and is_last marks the final one.
// A value yields 1 to 10 bytes. With signed_mode set (register 0, byte addresses
// 0 to 3, bit 0) the input is read as two's complement and first mapped to
// (magnitude << 1) | sign; the most negative value maps to 1. Writes to addresses
// 4 to 7 are dropped and read back as zero. Write signed_mode only while the
// block is idle. The single digit unit extracts one 7-bit digit per cycle into
// a small digit store, and every byte is then read through the store's
// registered port and offered until it is taken. value_ready is low from
// acceptance until the final byte has been taken.
module varint_encoder_msb_first
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // value channel
    input  logic [vienc_pkg::VALUE_W-1:0] value_bits,
    input  logic                          value_valid,
    output logic                          value_ready,
    // byte channel
    output logic [vienc_pkg::BYTE_W-1:0]  out_byte,
    output logic                          is_last,
    output logic                          byte_valid,
    input  logic                          byte_ready
);

    vienc_pkg::state_t             state_reg, state_next;
    logic [vienc_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [vienc_pkg::ADDR_W-1:0]  count_reg, count_next;
    logic [vienc_pkg::ADDR_W-1:0]  idx_reg, idx_next;
    logic                          signed_mode_reg, signed_mode_next;

    logic [vienc_pkg::VALUE_W-1:0] mapped_value;
    logic [vienc_pkg::VALUE_W-1:0] magnitude;
    vienc_pkg::digit_step_t        step;
    logic                          store_wr_en;
    logic                          store_rd_en;
    logic [vienc_pkg::DIGIT_W-1:0] store_rd_data;
    logic                          value_accept;
    logic                          byte_accept;
    logic                          cfg_write;

    // ------------------------------------------------------------------
    // Configuration port: single-bit mode register, no wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        signed_mode_next = signed_mode_reg;
        if (cfg_write && (paddr[2] == vienc_pkg::REG_SIGNED_MODE))
        begin
            signed_mode_next = pwdata[0];
        end
    end

    assign prdata = (paddr[2] == vienc_pkg::REG_SIGNED_MODE) ?
                    {31'b0, signed_mode_reg} : 32'b0;

    // ------------------------------------------------------------------
    // Signed mapping: (magnitude << 1) | sign, the shift drops bit 63
    // ------------------------------------------------------------------
    always_comb
    begin
        magnitude    = value_bits[vienc_pkg::VALUE_W-1] ? (~value_bits + 64'd1) : value_bits;
        mapped_value = signed_mode_reg ?
                       {magnitude[vienc_pkg::VALUE_W-2:0], value_bits[vienc_pkg::VALUE_W-1]} :
                       value_bits;
    end

    // ------------------------------------------------------------------
    // Shared digit unit and digit store
    // ------------------------------------------------------------------
    vienc_digit_unit u_digit_unit
    (
        .value       (value_reg),
        .digit_index (count_reg),
        .step        (step)
    );

    vienc_digit_store u_digit_store
    (
        .clk     (clk),
        .wr_en   (store_wr_en),
        .wr_addr (count_reg),
        .wr_data (step.digit),
        .rd_en   (store_rd_en),
        .rd_addr (idx_reg),
        .rd_data (store_rd_data)
    );

    // ------------------------------------------------------------------
    // Handshakes. The store's read register doubles as the output
    // register: it holds the offered digit while the byte side stalls.
    // ------------------------------------------------------------------
    assign value_ready  = (state_reg == vienc_pkg::ST_IDLE);
    assign byte_valid   = (state_reg == vienc_pkg::ST_WAIT);
    assign value_accept = value_valid && value_ready;
    assign byte_accept  = byte_valid && byte_ready;

    // the digit at index zero was extracted first and goes out last
    assign is_last  = (idx_reg == '0);
    assign out_byte = is_last ? {1'b0, store_rd_data} :
                      (vienc_pkg::CONT_BIT | {1'b0, store_rd_data});

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= vienc_pkg::ST_IDLE;
            value_reg       <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            signed_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            value_reg       <= value_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            signed_mode_reg <= signed_mode_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        value_next  = value_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        store_wr_en = 1'b0;
        store_rd_en = 1'b0;

        case (state_reg)
            vienc_pkg::ST_IDLE:
            begin
                // load the working value and restart the digit count
                if (value_accept)
                begin
                    value_next = mapped_value;
                    count_next = '0;
                    state_next = vienc_pkg::ST_EXTRACT;
                end
            end
            vienc_pkg::ST_EXTRACT:
            begin
                // store one digit per cycle, least significant first
                store_wr_en = 1'b1;
                if (step.done)
                begin
                    idx_next   = count_reg;
                    state_next = vienc_pkg::ST_READ;
                end
                else
                begin
                    value_next = step.next_value;
                    count_next = count_reg + vienc_pkg::ADDR_W'(1);
                end
            end
            vienc_pkg::ST_READ:
            begin
                store_rd_en = 1'b1;
                state_next  = vienc_pkg::ST_WAIT;
            end
            vienc_pkg::ST_WAIT:
            begin
                // hold the byte until taken, then advance toward index zero
                if (byte_accept)
                begin
                    if (is_last)
                    begin
                        state_next = vienc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - vienc_pkg::ADDR_W'(1);
                        state_next = vienc_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = vienc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(value_ready && byte_valid))
        else $error("value accepted while a byte is offered");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_accept && is_last) |=> value_ready)
        else $error("block not free after final byte");

    a_more_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_accept && !is_last) |=> (!byte_valid && !value_ready))
        else $error("missing read cycle between bytes");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        value_accept |=> (!value_ready && !byte_valid))
        else $error("extraction skipped after acceptance");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vienc_pkg::ST_EXTRACT) |->
        (count_reg <= vienc_pkg::ADDR_W'(vienc_pkg::MAX_BYTES - 1)))
        else $error("digit count beyond store depth");

endmodule

@@ hdl/vienc_digit_unit.sv @@
// Digit extraction unit: one bijective base-128 step per use.
module vienc_digit_unit
(
    input  logic [vienc_pkg::VALUE_W-1:0] value,
    input  logic [vienc_pkg::ADDR_W-1:0]  digit_index,
    output vienc_pkg::digit_step_t        step
);

    logic [vienc_pkg::VALUE_W-1:0] shifted;

    always_comb
    begin
        shifted         = value >> vienc_pkg::DIGIT_W;
        step.digit      = value[vienc_pkg::DIGIT_W-1:0] & vienc_pkg::DIGIT_MASK;
        step.next_value = shifted - vienc_pkg::VALUE_W'(1);
        // stop once the value fits one digit or the store is full
        step.done       = (shifted == '0) ||
                          (digit_index == vienc_pkg::ADDR_W'(vienc_pkg::MAX_BYTES - 1));
    end

endmodule

@@ hdl/vienc_digit_store.sv @@
// Digit store: small memory with one write port and one registered read port.
module vienc_digit_store
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [vienc_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [vienc_pkg::DIGIT_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [vienc_pkg::ADDR_W-1:0]  rd_addr,
    output logic [vienc_pkg::DIGIT_W-1:0] rd_data
);

    logic [vienc_pkg::DIGIT_W-1:0] mem [vienc_pkg::MAX_BYTES];
    logic [vienc_pkg::DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
